// ===== src/obb_pkg.sv =====
package obb_pkg;

    localparam int unsigned ANGLE_BITS   = 9;
    localparam int unsigned EXT_BITS     = 15;
    localparam int unsigned AXIS_BITS    = 3;
    localparam int unsigned FOLD_BITS    = 7;
    localparam int unsigned NUM_AXES     = 4;
    localparam int unsigned FULL_TURN    = 360;
    localparam int unsigned HALF_TURN    = 180;
    localparam int unsigned THREE_QUART  = 270;
    localparam int unsigned QUARTER_TURN = 90;
    localparam logic [63:0] PI_Q30       = 64'd3373259426;

    typedef logic [AXIS_BITS-1:0] t_axis;

    localparam t_axis AXIS_A_WIDTH  = 3'd0;
    localparam t_axis AXIS_A_HEIGHT = 3'd1;
    localparam t_axis AXIS_B_WIDTH  = 3'd2;
    localparam t_axis AXIS_B_HEIGHT = 3'd3;
    localparam t_axis AXIS_NONE     = 3'd4;

    // Sine of j degrees (0 to 90) in Q30 by the truncated odd power series.
    // Evaluated at elaboration only, to build the constant lookup table.
    function automatic logic [63:0] sin_q30(int unsigned j);
        logic [63:0] x;
        logic [63:0] t;
        longint      sum;
        x   = (64'(j) * PI_Q30) / 64'd180;
        t   = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        return 64'(sum);
    endfunction

    // Table entry rounded half up to f fraction bits.
    function automatic logic [63:0] sin_entry(int unsigned j, int unsigned f);
        logic [63:0] s;
        s = sin_q30(j);
        return (s + (64'd1 << (29 - f))) >> (30 - f);
    endfunction

endpackage

// ===== src/obb_if.sv =====
interface obb_in_if #(
    parameter int COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  a_center_x;
    logic signed [COORD_BITS-1:0]  a_center_y;
    logic [obb_pkg::EXT_BITS-1:0]   a_width;
    logic [obb_pkg::EXT_BITS-1:0]   a_height;
    logic [obb_pkg::ANGLE_BITS-1:0] a_angle;
    logic signed [COORD_BITS-1:0]  b_center_x;
    logic signed [COORD_BITS-1:0]  b_center_y;
    logic [obb_pkg::EXT_BITS-1:0]   b_width;
    logic [obb_pkg::EXT_BITS-1:0]   b_height;
    logic [obb_pkg::ANGLE_BITS-1:0] b_angle;

    modport source (
        output valid, a_center_x, a_center_y, a_width, a_height, a_angle,
               b_center_x, b_center_y, b_width, b_height, b_angle,
        input  ready
    );
    modport sink (
        input  valid, a_center_x, a_center_y, a_width, a_height, a_angle,
               b_center_x, b_center_y, b_width, b_height, b_angle,
        output ready
    );
endinterface

interface obb_out_if;
    logic               valid;
    logic               ready;
    logic               overlap;
    obb_pkg::t_axis     separating_axis;

    modport source (output valid, overlap, separating_axis, input ready);
    modport sink   (input valid, overlap, separating_axis, output ready);
endinterface

// ===== src/obb_trig.sv =====
module obb_trig #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [COORD_BITS-1:0]   i_ax,
    input  logic signed [COORD_BITS-1:0]   i_ay,
    input  logic signed [COORD_BITS-1:0]   i_bx,
    input  logic signed [COORD_BITS-1:0]   i_by,
    input  logic [obb_pkg::ANGLE_BITS-1:0] i_a_ang,
    input  logic [obb_pkg::ANGLE_BITS-1:0] i_b_ang,
    input  logic [obb_pkg::EXT_BITS-1:0]   i_ext [obb_pkg::NUM_AXES],
    output logic signed [COORD_BITS:0]     o_dx,
    output logic signed [COORD_BITS:0]     o_dy,
    output logic signed [TRIG_FRAC_BITS+1:0] o_ca,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sa,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cb,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sb,
    output logic [obb_pkg::EXT_BITS-1:0]   o_ext [obb_pkg::NUM_AXES]
);
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int AW = obb_pkg::ANGLE_BITS;
    localparam int FW = obb_pkg::FOLD_BITS;

    logic signed [TW-1:0] sin_tab [obb_pkg::QUARTER_TURN+1];

    for (genvar g = 0; g <= obb_pkg::QUARTER_TURN; g++) begin : g_tab
        localparam logic [63:0] ENTRY = obb_pkg::sin_entry(g, TRIG_FRAC_BITS);
        assign sin_tab[g] = ENTRY[TW-1:0];
    end

    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        logic [AW:0] r;
        r = (a >= (AW+1)'(obb_pkg::FULL_TURN)) ? a - (AW+1)'(obb_pkg::FULL_TURN) : a;
        return r[AW-1:0];
    endfunction

    // Folds an angle into the first quadrant and looks up its sine.
    function automatic logic signed [TW-1:0] lookup(input logic [AW-1:0] d,
                                                     input logic signed [TW-1:0] tab [91]);
        logic [AW-1:0] j;
        logic          neg;
        neg = 1'b0;
        if (d <= AW'(obb_pkg::QUARTER_TURN)) begin
            j = d;
        end else if (d <= AW'(obb_pkg::HALF_TURN)) begin
            j = AW'(obb_pkg::HALF_TURN) - d;
        end else if (d <= AW'(obb_pkg::THREE_QUART)) begin
            j = d - AW'(obb_pkg::HALF_TURN);
            neg = 1'b1;
        end else begin
            j = AW'(obb_pkg::FULL_TURN) - d;
            neg = 1'b1;
        end
        return neg ? -tab[j[FW-1:0]] : tab[j[FW-1:0]];
    endfunction

    logic [AW-1:0] a_deg, b_deg, a_cdeg, b_cdeg;

    always_comb begin
        a_deg  = wrap({1'b0, i_a_ang});
        b_deg  = wrap({1'b0, i_b_ang});
        a_cdeg = wrap({1'b0, a_deg} + (AW+1)'(obb_pkg::QUARTER_TURN));
        b_cdeg = wrap({1'b0, b_deg} + (AW+1)'(obb_pkg::QUARTER_TURN));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dx  <= (COORD_BITS+1)'(i_bx) - (COORD_BITS+1)'(i_ax);
            o_dy  <= (COORD_BITS+1)'(i_by) - (COORD_BITS+1)'(i_ay);
            o_sa  <= lookup(a_deg, sin_tab);
            o_ca  <= lookup(a_cdeg, sin_tab);
            o_sb  <= lookup(b_deg, sin_tab);
            o_cb  <= lookup(b_cdeg, sin_tab);
            o_ext <= i_ext;
        end
    end
endmodule

// ===== src/obb_proj.sv =====
module obb_proj #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_en_dot,
    input  logic                             i_en_ext,
    input  logic signed [COORD_BITS:0]       i_dx,
    input  logic signed [COORD_BITS:0]       i_dy,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_ca,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sa,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_cb,
    input  logic signed [TRIG_FRAC_BITS+1:0] i_sb,
    input  logic [obb_pkg::EXT_BITS-1:0]     i_ext [obb_pkg::NUM_AXES],
    output logic [COORD_BITS+TRIG_FRAC_BITS+3:0] o_abs_d [obb_pkg::NUM_AXES],
    output logic [TRIG_FRAC_BITS+obb_pkg::EXT_BITS+1:0]
                                             o_prod [obb_pkg::NUM_AXES][obb_pkg::NUM_AXES]
);
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int DW = COORD_BITS + F + 4;
    localparam int SW = 2 * F + 4;
    localparam int PW = F + obb_pkg::EXT_BITS + 2;
    localparam int N  = obb_pkg::NUM_AXES;

    logic signed [TW-1:0] ux [N];
    logic signed [TW-1:0] uy [N];
    logic signed [DW-1:0] d [N];
    logic signed [SW-1:0] s [N][N];
    logic [SW-1:0]        s_abs [N][N];

    // Second stage registers.
    logic [DW-1:0]  r_abs_d [N];
    logic [TW-1:0]  r_p [N][N];
    logic [obb_pkg::EXT_BITS-1:0] r_ext [N];

    always_comb begin
        ux[0] = i_ca;  uy[0] = i_sa;
        ux[1] = -i_sa; uy[1] = i_ca;
        ux[2] = i_cb;  uy[2] = i_sb;
        ux[3] = -i_sb; uy[3] = i_cb;
        for (int k = 0; k < N; k++) begin
            d[k] = DW'(i_dx * ux[k]) + DW'(i_dy * uy[k]);
            for (int i = 0; i < N; i++) begin
                s[k][i]     = SW'(ux[i] * ux[k]) + SW'(uy[i] * uy[k]);
                s_abs[k][i] = (s[k][i] < 0) ? $unsigned(-s[k][i]) : $unsigned(s[k][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_dot) begin
            r_ext <= i_ext;
            for (int k = 0; k < N; k++) begin
                r_abs_d[k] <= (d[k] < 0) ? $unsigned(-d[k]) : $unsigned(d[k]);
                for (int i = 0; i < N; i++) begin
                    // Round half up from 2F to F fraction bits.
                    r_p[k][i] <= TW'((s_abs[k][i] + (SW'(1) << (F - 1))) >> F);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_ext) begin
            o_abs_d <= r_abs_d;
            for (int k = 0; k < N; k++) begin
                for (int i = 0; i < N; i++) begin
                    o_prod[k][i] <= PW'(r_ext[i]) * PW'(r_p[k][i]);
                end
            end
        end
    end
endmodule

// ===== src/obb_sep.sv =====
module obb_sep #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [COORD_BITS+TRIG_FRAC_BITS+3:0] i_abs_d [obb_pkg::NUM_AXES],
    input  logic [TRIG_FRAC_BITS+obb_pkg::EXT_BITS+1:0]
                                 i_prod [obb_pkg::NUM_AXES][obb_pkg::NUM_AXES],
    output logic                 o_overlap,
    output obb_pkg::t_axis       o_axis
);
    localparam int DW = COORD_BITS + TRIG_FRAC_BITS + 4;
    localparam int PW = TRIG_FRAC_BITS + obb_pkg::EXT_BITS + 2;
    localparam int CW = (DW + 1 > PW + 2) ? DW + 2 : PW + 3;
    localparam int N  = obb_pkg::NUM_AXES;

    logic [CW-1:0]  radius [N];
    logic [N-1:0]   sep;
    obb_pkg::t_axis n_axis;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            radius[k] = CW'(i_prod[k][0]) + CW'(i_prod[k][1])
                      + CW'(i_prod[k][2]) + CW'(i_prod[k][3]);
            sep[k]    = (CW'(i_abs_d[k]) << 1) > radius[k];
        end
        priority if (sep[0]) begin
            n_axis = obb_pkg::AXIS_A_WIDTH;
        end else if (sep[1]) begin
            n_axis = obb_pkg::AXIS_A_HEIGHT;
        end else if (sep[2]) begin
            n_axis = obb_pkg::AXIS_B_WIDTH;
        end else if (sep[3]) begin
            n_axis = obb_pkg::AXIS_B_HEIGHT;
        end else begin
            n_axis = obb_pkg::AXIS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_axis    <= n_axis;
            o_overlap <= ~|sep;
        end
    end
endmodule

// ===== src/obb_overlap_test_2d.sv =====
// Throughput: one box pair per cycle while o_out.ready is high; four
// register stages (angle lookup, dot products, extent products, radius
// compare) each hold one item, and a pair reaches o_out through all four.
// Each stage holds only when the stage after it is full and stalled.
// Reset (i_rst_n low, synchronous) empties every stage; no table clearing.
module obb_overlap_test_2d #(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    obb_in_if.sink     i_in,
    obb_out_if.source  o_out
);
    localparam int F  = TRIG_FRAC_BITS;
    localparam int N  = obb_pkg::NUM_AXES;
    localparam int DW = COORD_BITS + F + 4;
    localparam int PW = F + obb_pkg::EXT_BITS + 2;

    logic [3:0] r_vld;
    logic [3:0] n_vld;
    logic [3:0] adv;

    logic signed [COORD_BITS:0] dx, dy;
    logic signed [F+1:0]        ca, sa, cb, sb;
    logic [obb_pkg::EXT_BITS-1:0] ext_in [N];
    logic [obb_pkg::EXT_BITS-1:0] ext_s1 [N];
    logic [DW-1:0]              abs_d [N];
    logic [PW-1:0]              prod [N][N];

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        adv[3] = ~r_vld[3] | o_out.ready;
        adv[2] = ~r_vld[2] | adv[3];
        adv[1] = ~r_vld[1] | adv[2];
        adv[0] = ~r_vld[0] | adv[1];
        n_vld[0] = adv[0] ? i_in.valid : r_vld[0];
        n_vld[1] = adv[1] ? r_vld[0]   : r_vld[1];
        n_vld[2] = adv[2] ? r_vld[1]   : r_vld[2];
        n_vld[3] = adv[3] ? r_vld[2]   : r_vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready = adv[0];
    assign o_out.valid = r_vld[3];

    always_comb begin
        ext_in[0] = i_in.a_width;
        ext_in[1] = i_in.a_height;
        ext_in[2] = i_in.b_width;
        ext_in[3] = i_in.b_height;
    end

    obb_trig #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(F)) u_trig (
        .i_clk   (i_clk),
        .i_en    (adv[0]),
        .i_ax    (i_in.a_center_x),
        .i_ay    (i_in.a_center_y),
        .i_bx    (i_in.b_center_x),
        .i_by    (i_in.b_center_y),
        .i_a_ang (i_in.a_angle),
        .i_b_ang (i_in.b_angle),
        .i_ext   (ext_in),
        .o_dx    (dx),
        .o_dy    (dy),
        .o_ca    (ca),
        .o_sa    (sa),
        .o_cb    (cb),
        .o_sb    (sb),
        .o_ext   (ext_s1)
    );

    obb_proj #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(F)) u_proj (
        .i_clk    (i_clk),
        .i_en_dot (adv[1]),
        .i_en_ext (adv[2]),
        .i_dx     (dx),
        .i_dy     (dy),
        .i_ca     (ca),
        .i_sa     (sa),
        .i_cb     (cb),
        .i_sb     (sb),
        .i_ext    (ext_s1),
        .o_abs_d  (abs_d),
        .o_prod   (prod)
    );

    obb_sep #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(F)) u_sep (
        .i_clk     (i_clk),
        .i_en      (adv[3]),
        .i_abs_d   (abs_d),
        .i_prod    (prod),
        .o_overlap (o_out.overlap),
        .o_axis    (o_out.separating_axis)
    );

`ifndef SYNTHESIS
    a_overlap_matches_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.overlap == (o_out.separating_axis == obb_pkg::AXIS_NONE)))
        else $error("overlap flag disagrees with separating axis");

    a_axis_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.separating_axis <= obb_pkg::AXIS_NONE))
        else $error("separating axis code out of range");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid directly after reset");

    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while every stage is full and stalled");
`endif
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC     = 15;
    localparam int LIMIT    = 5000;
    localparam int N_RANDOM = 1800;

    typedef struct packed {
        logic signed [15:0]             ax;
        logic signed [15:0]             ay;
        logic [obb_pkg::EXT_BITS-1:0]   aw;
        logic [obb_pkg::EXT_BITS-1:0]   ah;
        logic [obb_pkg::ANGLE_BITS-1:0] aa;
        logic signed [15:0]             bx;
        logic signed [15:0]             by;
        logic [obb_pkg::EXT_BITS-1:0]   bw;
        logic [obb_pkg::EXT_BITS-1:0]   bh;
        logic [obb_pkg::ANGLE_BITS-1:0] ba;
    } t_pair;

    localparam int PAIR_BITS = $bits(t_pair);

    typedef struct packed {
        logic           overlap;
        obb_pkg::t_axis axis;
    } t_verdict;

    // A directed row; the verdict is only typed in where it is obvious.
    typedef struct {
        t_pair    pair;
        bit       known;
        t_verdict verdict;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    obb_in_if  #(.COORD_BITS(16)) in_ch ();
    obb_out_if                    out_ch ();

    obb_overlap_test_2d #(.COORD_BITS(16), .TRIG_FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    t_verdict verdicts_due[$];
    longint   sine_tab[0:90];
    int       n_errors = 0;
    int       n_sent = 0;
    int       n_overlaps = 0;
    int       n_separated = 0;
    int       idle_cycles = 0;
    bit       long_hold = 1'b0;

    // Sine of a first-quadrant angle by the odd power series in Q30, rounded to FRAC fraction bits.
    function automatic longint series_sine(int j);
        longint unsigned x;
        longint unsigned t;
        longint          acc;
        x   = (longint'(j) * 64'd3373259426) / 180;
        t   = x;
        acc = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc -= longint'(t);
            end else begin
                acc += longint'(t);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
        return (acc + (longint'(1) << (29 - FRAC))) >> (30 - FRAC);
    endfunction

    function automatic longint sine_deg(int deg);
        if (deg <= 90) return sine_tab[deg];
        if (deg <= 180) return sine_tab[180 - deg];
        if (deg <= 270) return -sine_tab[deg - 180];
        return -sine_tab[360 - deg];
    endfunction

    function automatic t_verdict separation_test(t_pair p);
        longint   nx[4], ny[4], ext[4];
        longint   dx, dy, d, r, pr, ca, sa, cb, sb;
        int       angle_a, angle_b;
        t_verdict v;
        dx = longint'(p.bx) - longint'(p.ax);
        dy = longint'(p.by) - longint'(p.ay);
        angle_a = int'(p.aa) % 360;
        angle_b = int'(p.ba) % 360;
        ca = sine_deg((angle_a + 90) % 360);
        sa = sine_deg(angle_a);
        cb = sine_deg((angle_b + 90) % 360);
        sb = sine_deg(angle_b);
        nx[0] = ca;  ny[0] = sa;
        nx[1] = -sa; ny[1] = ca;
        nx[2] = cb;  ny[2] = sb;
        nx[3] = -sb; ny[3] = cb;
        ext[0] = longint'(p.aw); ext[1] = longint'(p.ah);
        ext[2] = longint'(p.bw); ext[3] = longint'(p.bh);
        v.overlap = 1'b1;
        v.axis    = obb_pkg::AXIS_NONE;
        for (int k = 0; k < 4; k++) begin
            d = dx * nx[k] + dy * ny[k];
            if (d < 0) d = -d;
            r = 0;
            for (int i = 0; i < 4; i++) begin
                pr = nx[i] * nx[k] + ny[i] * ny[k];
                if (pr < 0) pr = -pr;
                pr = (pr + (longint'(1) << (FRAC - 1))) >> FRAC;
                r += ext[i] * pr;
            end
            if (v.overlap && 2 * d > r) begin
                v.overlap = 1'b0;
                v.axis    = obb_pkg::t_axis'(k);
            end
        end
        return v;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int    mode;
        mode = $urandom_range(0, 9);
        p = t_pair'(PAIR_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        // Mostly boxes of comparable size near each other, so that every
        // axis gets to decide; the rest is unconstrained noise.
        if (mode < 7) begin
            p.ax = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.ay = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.bx = p.ax + 16'($signed($urandom_range(0, 3000)) - 1500);
            p.by = p.ay + 16'($signed($urandom_range(0, 3000)) - 1500);
            p.aw = obb_pkg::EXT_BITS'($urandom_range(0, 2000));
            p.ah = obb_pkg::EXT_BITS'($urandom_range(0, 2000));
            p.bw = obb_pkg::EXT_BITS'($urandom_range(0, 2000));
            p.bh = obb_pkg::EXT_BITS'($urandom_range(0, 2000));
        end
        if (mode < 9) begin
            p.aa = obb_pkg::ANGLE_BITS'($urandom_range(0, 359));
            p.ba = obb_pkg::ANGLE_BITS'($urandom_range(0, 359));
        end
        return p;
    endfunction

    // Offers one pair and holds it until the transfer completes.
    task automatic offer_pair(t_pair p);
        in_ch.valid      <= 1'b1;
        in_ch.a_center_x <= p.ax;
        in_ch.a_center_y <= p.ay;
        in_ch.a_width    <= p.aw;
        in_ch.a_height   <= p.ah;
        in_ch.a_angle    <= p.aa;
        in_ch.b_center_x <= p.bx;
        in_ch.b_center_y <= p.by;
        in_ch.b_width    <= p.bw;
        in_ch.b_height   <= p.bh;
        in_ch.b_angle    <= p.ba;
        do @(posedge i_clk); while (!in_ch.ready);
        verdicts_due.push_back(separation_test(p));
        n_sent++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.a_center_x = '0;
        in_ch.a_center_y = '0;
        in_ch.a_width    = '0;
        in_ch.a_height   = '0;
        in_ch.a_angle    = '0;
        in_ch.b_center_x = '0;
        in_ch.b_center_y = '0;
        in_ch.b_width    = '0;
        in_ch.b_height   = '0;
        in_ch.b_angle    = '0;
        out_ch.ready     = 1'b0;
    end

    // Receiver: a stall pattern of its own, and one long hold-off while
    // the sender keeps offering.
    always @(posedge i_clk) begin
        if (long_hold) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (($urandom_range(0, 63) + n_sent / 128) % 4)
                0: out_ch.ready <= 1'b0;
                default: out_ch.ready <= ($urandom_range(0, 3) != 0) || n_sent % 256 < 64;
            endcase
        end
    end

    initial begin
        wait (n_sent == 400);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (80) @(posedge i_clk);
        long_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result with no pair outstanding");
                n_errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (out_ch.overlap !== want.overlap) begin
                    $error("overlap: expected %0d, got %0d", want.overlap, out_ch.overlap);
                    n_errors++;
                end
                if (out_ch.separating_axis !== want.axis) begin
                    $error("separating_axis: expected %0d, got %0d",
                           want.axis, out_ch.separating_axis);
                    n_errors++;
                end
                if (want.overlap) n_overlaps++;
                else n_separated++;
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= LIMIT) begin
            $display("timeout with %0d results outstanding", verdicts_due.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_row rows[$];

    function automatic t_pair make_pair(int ax, int ay, int aw, int ah, int aa,
                                        int bx, int by, int bw, int bh, int ba);
        t_pair p;
        p.ax = 16'(ax); p.ay = 16'(ay); p.aw = 15'(aw); p.ah = 15'(ah);
        p.aa = 9'(aa);  p.bx = 16'(bx); p.by = 16'(by); p.bw = 15'(bw);
        p.bh = 15'(bh); p.ba = 9'(ba);
        return p;
    endfunction

    function automatic void add_row(t_pair p, bit known, logic ov, obb_pkg::t_axis ax);
        t_row r;
        r.pair = p;
        r.known = known;
        r.verdict.overlap = ov;
        r.verdict.axis = ax;
        rows.push_back(r);
    endfunction

    initial begin
        t_pair p;
        for (int j = 0; j <= 90; j++) sine_tab[j] = series_sine(j);

        // Identical centres always overlap; unrotated boxes far apart in x
        // are split by the width axis of the first box.
        add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1, obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 10, 10, 0, 100, 0, 10, 10, 0), 1, 1'b0,
                obb_pkg::AXIS_A_WIDTH);
        add_row(make_pair(0, 0, 10, 10, 0, 0, 100, 10, 10, 0), 1, 1'b0,
                obb_pkg::AXIS_A_HEIGHT);
        // Touching edges count as overlap.
        add_row(make_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0), 1, 1'b1,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 10, 10, 0, 11, 0, 10, 10, 0), 1, 1'b0,
                obb_pkg::AXIS_A_WIDTH);
        add_row(make_pair(-32768, -32768, 32767, 32767, 359,
                          32767, 32767, 32767, 32767, 359), 0, 1'b0, obb_pkg::AXIS_NONE);
        add_row(make_pair(32767, -32768, 0, 32767, 90,
                          -32768, 32767, 32767, 0, 270), 0, 1'b0, obb_pkg::AXIS_NONE);
        add_row(make_pair(-32768, 32767, 32767, 32767, 0,
                          32767, -32768, 32767, 32767, 0), 0, 1'b0, obb_pkg::AXIS_NONE);
        // Angles above a full turn wrap round.
        add_row(make_pair(0, 0, 100, 20, 511, 60, 40, 100, 20, 360), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 100, 20, 400, 60, 40, 100, 20, 45), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 100, 4, 45, 0, 80, 100, 4, 135), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 4, 100, 0, 60, 60, 100, 4, 45), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(5, 5, 100, 100, 180, -200, 5, 30, 30, 30), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 30, 400, 60, 250, 0, 30, 400, 300), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 200, 10, 10, 100, 100, 10, 200, 100), 0, 1'b0,
                obb_pkg::AXIS_NONE);
        add_row(make_pair(0, 0, 1, 1, 270, 3, 3, 2, 2, 89), 0, 1'b0, obb_pkg::AXIS_NONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].known && separation_test(rows[i].pair) != rows[i].verdict) begin
                $error("row %0d: predictor disagrees with the typed-in verdict", i);
                n_errors++;
            end
            offer_pair(rows[i].pair);
            pause_sender();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            p = random_pair();
            offer_pair(p);
            if (i % 300 > 200) pause_sender();
        end
        in_ch.valid <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d box pairs sent: %0d overlapping, %0d separated",
                 n_sent, n_overlaps, n_separated);
        $display("directed edge, touching and wrapped-angle cases plus random pairs");
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== obb_overlap_test_2d.f =====
src/obb_pkg.sv
src/obb_if.sv
src/obb_trig.sv
src/obb_proj.sv
src/obb_sep.sv
src/obb_overlap_test_2d.sv
dv/testbench.sv
